>>> rtl/core/sle_pkg.sv
// shared types and constants for the serial line editor
// no dependencies
package sle_pkg;

  localparam int LINE_LEN_DEF = 16;

  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_DEL = 8'h7f;
  localparam logic [7:0] CH_NBSP = 8'ha0;
  localparam logic [7:0] CTRL_C = 8'h03;
  localparam logic [7:0] CTRL_R = 8'h12;
  localparam logic [7:0] CTRL_U = 8'h15;
  localparam logic [7:0] CTRL_W = 8'h17;

  localparam logic [1:0] KIND_ECHO   = 2'd0;
  localparam logic [1:0] KIND_LINE   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] STAT_FRAME   = 2'd0;
  localparam logic [1:0] STAT_OVERRUN = 2'd1;
  localparam logic [1:0] STAT_INTR    = 2'd2;

  typedef struct packed {
    logic       last;
    logic [1:0] status_code;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
  } res_t;

endpackage

>>> rtl/core/sle_line_mem.sv
// line store: one write port, one read port with registered read data
// depends on sle_pkg for its default length
module sle_line_mem #(
  parameter int LINE_LEN = sle_pkg::LINE_LEN_DEF,
  localparam int AW = $clog2(LINE_LEN)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [LINE_LEN];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/sle_seq.sv
// editing sequencer: decodes a request, walks the line store, fills
// an output register, one result a cycle when free; uses sle_pkg
module sle_seq #(
  parameter int LINE_LEN = sle_pkg::LINE_LEN_DEF,
  localparam int AW = $clog2(LINE_LEN)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_fe,
  input  logic          in_ov,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [7:0]    mem_rdata,
  output logic          res_valid,
  input  logic          res_ready,
  output sle_pkg::res_t res
);
  import sle_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ONE   = 3'd1;
  localparam logic [2:0] S_CRLF  = 3'd2;
  localparam logic [2:0] S_LINE  = 3'd3;
  localparam logic [2:0] S_WCHK  = 3'd4;
  localparam logic [2:0] S_ERASE = 3'd5;

  localparam logic [2:0] OP_ERASE1   = 3'd0;
  localparam logic [2:0] OP_ERASEALL = 3'd1;
  localparam logic [2:0] OP_WERASE   = 3'd2;
  localparam logic [2:0] OP_NEWLINE  = 3'd3;
  localparam logic [2:0] OP_REPRINT  = 3'd4;

  localparam logic [AW-1:0] FILL_MAX = AW'(LINE_LEN - 1);
  localparam logic [AW-1:0] ONE_A = AW'(1);
  localparam logic [AW-1:0] TWO_A = AW'(2);

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [1:0]    sub_r, sub_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [1:0]    code_r, code_nxt;
  logic          ov_r;
  res_t          res_r;

  logic          slot_free;
  logic          accept;
  logic          emit;
  res_t          item;
  logic [7:0]    c;
  logic          printable;
  logic          fin;

  assign slot_free = !ov_r || res_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;

  always_comb begin
    c = in_byte;
    if (in_byte == CH_CR) begin
      c = CH_LF;
    end else if (in_byte == CH_TAB) begin
      c = CH_SP;
    end
  end

  assign printable = (c >= CH_SP && c <= CH_TILDE) || c >= CH_NBSP;
  assign mem_waddr = fill_r;
  assign mem_wdata = c;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    sub_nxt   = sub_r;
    idx_nxt   = idx_r;
    fill_nxt  = fill_r;
    byte_nxt  = byte_r;
    kind_nxt  = kind_r;
    code_nxt  = code_r;
    mem_we    = 1'b0;
    emit      = 1'b0;
    item      = '0;
    fin       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_fe || in_ov || c == CTRL_C) begin
            fill_nxt  = '0;
            byte_nxt  = '0;
            kind_nxt  = KIND_STATUS;
            code_nxt  = in_fe ? STAT_FRAME : (in_ov ? STAT_OVERRUN : STAT_INTR);
            state_nxt = S_ONE;
          end else if (c == CH_LF) begin
            op_nxt    = OP_NEWLINE;
            sub_nxt   = 2'd0;
            idx_nxt   = '0;
            state_nxt = S_CRLF;
          end else if (printable) begin
            kind_nxt = KIND_ECHO;
            code_nxt = '0;
            if (fill_r == FILL_MAX) begin
              byte_nxt = CH_BEL;
            end else begin
              mem_we   = 1'b1;
              byte_nxt = c;
              fill_nxt = fill_r + ONE_A;
            end
            state_nxt = S_ONE;
          end else if ((c == CH_BS || c == CH_DEL) && fill_r != '0) begin
            op_nxt    = OP_ERASE1;
            sub_nxt   = 2'd0;
            state_nxt = S_ERASE;
          end else if (c == CTRL_R) begin
            op_nxt    = OP_REPRINT;
            sub_nxt   = 2'd0;
            idx_nxt   = '0;
            state_nxt = S_CRLF;
          end else if (c == CTRL_U && fill_r != '0) begin
            op_nxt    = OP_ERASEALL;
            sub_nxt   = 2'd0;
            state_nxt = S_ERASE;
          end else if (c == CTRL_W && fill_r != '0) begin
            op_nxt    = OP_WERASE;
            sub_nxt   = 2'd0;
            state_nxt = S_WCHK;
          end
        end
      end
      S_ONE: begin
        if (slot_free) begin
          emit             = 1'b1;
          item.out_byte    = byte_r;
          item.out_kind    = kind_r;
          item.status_code = code_r;
          item.last        = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_CRLF: begin
        if (slot_free) begin
          emit          = 1'b1;
          item.out_kind = KIND_ECHO;
          if (sub_r == 2'd0) begin
            item.out_byte = CH_CR;
            if (op_r == OP_REPRINT) begin
              item.last = (fill_r == '0);
              state_nxt = (fill_r == '0) ? S_IDLE : S_LINE;
            end else begin
              sub_nxt = 2'd1;
            end
          end else begin
            item.out_byte = CH_LF;
            state_nxt     = S_LINE;
          end
        end
      end
      S_LINE: begin
        if (slot_free) begin
          emit = 1'b1;
          if (idx_r == fill_r) begin
            item.out_byte = CH_LF;
            item.out_kind = KIND_LINE;
            item.last     = 1'b1;
            fill_nxt      = '0;
            state_nxt     = S_IDLE;
          end else begin
            item.out_byte = mem_rdata;
            item.out_kind = (op_r == OP_NEWLINE) ? KIND_LINE : KIND_ECHO;
            item.last     = (op_r == OP_REPRINT) && (idx_r == fill_r - ONE_A);
            idx_nxt       = idx_r + ONE_A;
            if (item.last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_WCHK: begin
        state_nxt = (mem_rdata == CH_SP) ? S_IDLE : S_ERASE;
      end
      S_ERASE: begin
        if (slot_free) begin
          emit          = 1'b1;
          item.out_kind = KIND_ECHO;
          item.out_byte = (sub_r == 2'd1) ? CH_SP : CH_BS;
          if (sub_r != 2'd2) begin
            sub_nxt = sub_r + 2'd1;
          end else begin
            sub_nxt  = 2'd0;
            fill_nxt = fill_r - ONE_A;
            case (op_r)
              OP_ERASE1:   fin = 1'b1;
              OP_ERASEALL: fin = (fill_r == ONE_A);
              OP_WERASE:   fin = (fill_r == ONE_A) || (mem_rdata == CH_SP);
              default:     fin = 1'b1;
            endcase
            item.last = fin;
            if (fin) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // word erase looks at the character before the one being erased
  always_comb begin
    if (state_nxt == S_WCHK) begin
      mem_raddr = fill_r - ONE_A;
    end else if (op_nxt == OP_WERASE) begin
      mem_raddr = fill_r - TWO_A;
    end else begin
      mem_raddr = idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (res_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    sub_r  <= sub_nxt;
    idx_r  <= idx_nxt;
    byte_r <= byte_nxt;
    kind_r <= kind_nxt;
    code_r <= code_nxt;
    if (emit) begin
      res_r <= item;
    end
  end

  assign res_valid = ov_r;
  assign res       = res_r;

endmodule

>>> rtl/core/serial_line_editor.sv
// top level of the serial line editor: sequencer plus line store
// depends on sle_pkg, sle_line_mem and sle_seq
//
// Each received byte is taken, after which the block is busy until it has produced every
// result of that byte, one result per cycle while the output side takes them; a Ctrl-W
// first looks at the character before the cursor. A line of n characters emits in n + 3
// results; a full line erase gives three results per character, so the worst case is
// 3 * (LINE_LEN - 1) results, 45 at the default length. The line store has a single read
// port with registered read data and the sequencer reads it one entry ahead so that stored
// characters leave at one per cycle while the output side takes them. The output register
// lets the next byte be taken while the last result still waits.
module serial_line_editor #(
  parameter int LINE_LEN = sle_pkg::LINE_LEN_DEF,
  localparam int AW = $clog2(LINE_LEN)
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // rx_byte
  input  logic [1:0] in_tuser,   // frame_error, overrun
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic [3:0] out_tuser,  // out_kind[1:0], status_code[1:0]
  output logic       out_tlast
);
  import sle_pkg::*;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  res_t          res;

  sle_seq #(.LINE_LEN(LINE_LEN)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_fe     (in_tuser[0]),
    .in_ov     (in_tuser[1]),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  sle_line_mem #(.LINE_LEN(LINE_LEN)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_tdata = res.out_byte;
  assign out_tuser = {res.status_code, res.out_kind};
  assign out_tlast = res.last;

endmodule

>>> rtl/core/sle_checker.sv
// port-level checks on the serial line editor results
// depends on sle_pkg; bound to serial_line_editor
module sle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic [1:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [3:0] out_tuser,
  input logic       out_tlast
);
  import sle_pkg::*;

  logic unused_in;
  assign unused_in = in_tvalid ^ in_tready ^ (^in_tdata) ^ (^in_tuser);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_STATUS |-> out_tlast)
    else $error("status result not last");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_STATUS |-> out_tdata == 8'h00)
    else $error("status result carries data");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[1:0] != 2'd3)
    else $error("unknown result kind");

  a_code_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != KIND_STATUS |-> out_tuser[3:2] == 2'd0)
    else $error("status code on non-status result");

endmodule

bind serial_line_editor sle_checker u_sle_checker (.*);

>>> test/tb_serial_line_editor.sv
// self-checking testbench for serial_line_editor: directed edits, then random lines and noise
// keeps its own line buffer to predict echo, line and status results; depends on sle_pkg
module tb_serial_line_editor;
  import sle_pkg::*;

  localparam int LINE_LEN = LINE_LEN_DEF;
  localparam int RANDOM_ITEMS = 450;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_REPORTS = 60;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic [1:0] in_tuser = 2'b00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [3:0] out_tuser;
  logic       out_tlast;

  logic [7:0] shadow_line [LINE_LEN];
  int         shadow_fill = 0;
  res_t       pending_results [$];
  int         errors = 0;
  int         sent_items = 0;
  bit         idle_en = 1'b1;
  int         stall_left = 0;

  serial_line_editor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #120000000;
    $display("[serial_line_editor] ERROR");
    $finish;
  end

  function automatic void push_result(input logic [7:0] b, input logic [1:0] kind,
                                      input logic [1:0] code);
    res_t r;
    r.out_byte = b;
    r.out_kind = kind;
    r.status_code = code;
    r.last = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic int rub_out();
    push_result(CH_BS, KIND_ECHO, STAT_FRAME);
    push_result(CH_SP, KIND_ECHO, STAT_FRAME);
    push_result(CH_BS, KIND_ECHO, STAT_FRAME);
    shadow_fill--;
    return 3;
  endfunction

  // returns how many results the request causes
  function automatic int line_discipline(input logic [7:0] rx, input logic fe,
                                         input logic ov);
    logic [7:0] c;
    int n;
    n = 0;
    c = rx;
    if (fe || ov || c == CTRL_C) begin
      shadow_fill = 0;
      push_result(8'h00, KIND_STATUS, fe ? STAT_FRAME : (ov ? STAT_OVERRUN : STAT_INTR));
      n = 1;
    end else begin
      if (c == CH_CR) c = CH_LF;
      if (c == CH_TAB) c = CH_SP;
      if (c == CH_LF) begin
        push_result(CH_CR, KIND_ECHO, STAT_FRAME);
        push_result(CH_LF, KIND_ECHO, STAT_FRAME);
        for (int i = 0; i < shadow_fill; i++) push_result(shadow_line[i], KIND_LINE, STAT_FRAME);
        push_result(CH_LF, KIND_LINE, STAT_FRAME);
        n = shadow_fill + 3;
        shadow_fill = 0;
      end else if ((c >= CH_SP && c <= CH_TILDE) || c >= CH_NBSP) begin
        if (shadow_fill >= LINE_LEN - 1) begin
          push_result(CH_BEL, KIND_ECHO, STAT_FRAME);
        end else begin
          shadow_line[shadow_fill] = c;
          shadow_fill++;
          push_result(c, KIND_ECHO, STAT_FRAME);
        end
        n = 1;
      end else if (c == CH_BS || c == CH_DEL) begin
        if (shadow_fill > 0) n = rub_out();
      end else if (c == CTRL_R) begin
        push_result(CH_CR, KIND_ECHO, STAT_FRAME);
        for (int i = 0; i < shadow_fill; i++) push_result(shadow_line[i], KIND_ECHO, STAT_FRAME);
        n = shadow_fill + 1;
      end else if (c == CTRL_U) begin
        while (shadow_fill > 0) n += rub_out();
      end else if (c == CTRL_W) begin
        // no skipping of trailing spaces
        while (shadow_fill > 0 && shadow_line[shadow_fill - 1] != CH_SP) n += rub_out();
      end
    end
    if (n > 0) pending_results[$].last = 1'b1;
    return n;
  endfunction

  task automatic send_rx(input logic [7:0] b, input logic fe = 1'b0, input logic ov = 1'b0);
    int gap;
    int r;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= {ov, fe};
    do @(posedge clk); while (!in_tready);
    void'(line_discipline(b, fe, ov));
    sent_items++;
    gap = 0;
    if (idle_en) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(10, 40);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off requests until every result is out, then let a quiet item finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!idle_en || $urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    end
  end

  task automatic report(input string field, input logic [7:0] exp, input logic [7:0] act);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp, act);
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual byte %h user %h last %b",
                   $time, out_tdata, out_tuser, out_tlast);
      end else begin
        e = pending_results.pop_front();
        if (out_tdata !== e.out_byte) report("out_byte", e.out_byte, out_tdata);
        if (out_tuser[1:0] !== e.out_kind)
          report("out_kind", 8'(e.out_kind), 8'(out_tuser[1:0]));
        if (out_tuser[3:2] !== e.status_code)
          report("status_code", 8'(e.status_code), 8'(out_tuser[3:2]));
        if (out_tlast !== e.last) report("last", 8'(e.last), 8'(out_tlast));
      end
    end
  end

  function automatic logic [7:0] rand_glyph();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return CH_SP;
    if (r < 65) return 8'($urandom_range(8'h21, 8'h7e));
    return 8'($urandom_range(8'ha0, 8'hff));
  endfunction

  function automatic logic [7:0] rand_edit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return CH_BS;
    if (r < 50) return CH_DEL;
    if (r < 75) return CTRL_W;
    if (r < 85) return CTRL_R;
    if (r < 92) return CH_TAB;
    return CTRL_U;
  endfunction

  task automatic test_empty_line_edits();
    send_rx(CH_BS);
    send_rx(CTRL_W);
    send_rx(CTRL_U);
    send_rx(8'h00);
    send_rx(8'h9f);
  endtask

  task automatic test_line_full();
    send_rx(CH_SP);
    send_rx(CH_TILDE);
    send_rx(CH_NBSP);
    send_rx(8'hff);
    for (int i = 4; i < LINE_LEN - 1; i++) send_rx((i == 8) ? CH_TAB : 8'h61 + 8'(i));
    send_rx(8'h41);
  endtask

  task automatic test_erase_and_reprint();
    send_rx(CTRL_R);
    send_rx(CH_DEL);
    send_rx(CH_BS);
    send_rx(CTRL_W);
    send_rx(CTRL_W);
    send_rx(CH_CR);
  endtask

  task automatic test_line_kill_and_interrupt();
    send_rx(8'h78);
    send_rx(CTRL_U);
    send_rx(CH_LF);
    send_rx(8'h79);
    send_rx(CTRL_C);
  endtask

  task automatic test_receiver_errors();
    send_rx(8'h7a, 1'b1, 1'b0);
    send_rx(8'h41, 1'b0, 1'b1);
    send_rx(CTRL_C, 1'b1, 1'b1);
  endtask

  task automatic test_random_lines();
    int len;
    int r;
    bit drained;
    drained = 1'b0;
    while (sent_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) idle_en = !idle_en;
      if (!drained && sent_items > RANDOM_ITEMS / 2) begin
        wait_idle();
        drained = 1'b1;
      end
      if ($urandom_range(0, 99) < 70) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 20);
        for (int i = 0; i < len; i++)
          send_rx(($urandom_range(0, 99) < 75) ? rand_glyph() : rand_edit());
        r = $urandom_range(0, 99);
        if (r < 45) send_rx(CH_CR);
        else if (r < 85) send_rx(CH_LF);
        else if (r < 93) send_rx(CTRL_C);
        else if (r < 97) send_rx(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
        else send_rx(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end else begin
        send_rx(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0),
                ($urandom_range(0, 15) == 0));
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_line_edits();
    test_line_full();
    wait_idle();
    test_erase_and_reprint();
    test_line_kill_and_interrupt();
    test_receiver_errors();
    wait_idle();
    test_random_lines();
    wait_idle();
    if (errors == 0) begin
      $display("[serial_line_editor] OK");
    end else begin
      $display("[serial_line_editor] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/sle_pkg.sv
rtl/core/sle_line_mem.sv
rtl/core/sle_seq.sv
rtl/core/serial_line_editor.sv
rtl/core/sle_checker.sv
test/tb_serial_line_editor.sv
